// File: hw/rtl/sqlx_pkg.sv
`default_nettype none
package sqlx_pkg;

  localparam int unsigned TextBytesMax = 65536;
  localparam int unsigned KwLenMax = 17;
  localparam int unsigned CountMax = (TextBytesMax - 1 > 65535) ? 65535 : TextBytesMax - 1;
  localparam int unsigned NumKw = 41;
  localparam int unsigned QueueDepth = 4;

  localparam logic [6:0] K_IDENT = 7'd41;
  localparam logic [6:0] K_NUMBER = 7'd42;
  localparam logic [6:0] K_STRING = 7'd43;
  localparam logic [6:0] K_EQUAL = 7'd44;
  localparam logic [6:0] K_BANG_EQUAL = 7'd45;
  localparam logic [6:0] K_LESS = 7'd46;
  localparam logic [6:0] K_LESS_EQUAL = 7'd47;
  localparam logic [6:0] K_LESS_GREATER = 7'd48;
  localparam logic [6:0] K_GREATER = 7'd49;
  localparam logic [6:0] K_GREATER_EQUAL = 7'd50;
  localparam logic [6:0] K_SINGLE_BASE = 7'd51;
  localparam logic [6:0] K_DOT = 7'd62;
  localparam logic [6:0] K_EOF = 7'd64;
  localparam logic [6:0] K_ERROR = 7'd65;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_CHAR = 2'd1;
  localparam logic [1:0] E_STRING = 2'd2;
  localparam logic [1:0] E_QIDENT = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_STRING,
    M_STRING_QUOTE, M_QIDENT, M_BANG, M_LESS, M_GREATER
  } mode_t;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic [1:0]  err;
    logic        last;
  } tok_t;

  // Group of up to three tokens made by one byte.
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } grp_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    sat_inc = (x == 16'(CountMax)) ? x : x + 16'd1;
  endfunction

  function automatic logic [4:0] kw_len(input logic [5:0] k);
    if (k < 6'd5) kw_len = 5'd2;
    else if (k < 6'd9) kw_len = 5'd3;
    else if (k < 6'd21) kw_len = 5'd4;
    else if (k < 6'd29) kw_len = 5'd5;
    else if (k < 6'd32) kw_len = 5'd6;
    else if (k < 6'd34) kw_len = 5'd7;
    else if (k < 6'd35) kw_len = 5'd8;
    else if (k < 6'd37) kw_len = 5'd9;
    else if (k < 6'd39) kw_len = 5'd12;
    else if (k < 6'd40) kw_len = 5'd14;
    else kw_len = 5'd17;
  endfunction

  // keyword text, last character in the low byte
  function automatic logic [8*KwLenMax-1:0] kw_text(input logic [5:0] k);
    case (k)
      6'd0: kw_text = (8*KwLenMax)'("IN");
      6'd1: kw_text = (8*KwLenMax)'("IS");
      6'd2: kw_text = (8*KwLenMax)'("OR");
      6'd3: kw_text = (8*KwLenMax)'("AS");
      6'd4: kw_text = (8*KwLenMax)'("BY");
      6'd5: kw_text = (8*KwLenMax)'("AND");
      6'd6: kw_text = (8*KwLenMax)'("NOT");
      6'd7: kw_text = (8*KwLenMax)'("END");
      6'd8: kw_text = (8*KwLenMax)'("ASC");
      6'd9: kw_text = (8*KwLenMax)'("FROM");
      6'd10: kw_text = (8*KwLenMax)'("LIKE");
      6'd11: kw_text = (8*KwLenMax)'("NULL");
      6'd12: kw_text = (8*KwLenMax)'("TRUE");
      6'd13: kw_text = (8*KwLenMax)'("CASE");
      6'd14: kw_text = (8*KwLenMax)'("WHEN");
      6'd15: kw_text = (8*KwLenMax)'("THEN");
      6'd16: kw_text = (8*KwLenMax)'("ELSE");
      6'd17: kw_text = (8*KwLenMax)'("DESC");
      6'd18: kw_text = (8*KwLenMax)'("LAST");
      6'd19: kw_text = (8*KwLenMax)'("DATE");
      6'd20: kw_text = (8*KwLenMax)'("TIME");
      6'd21: kw_text = (8*KwLenMax)'("WHERE");
      6'd22: kw_text = (8*KwLenMax)'("FALSE");
      6'd23: kw_text = (8*KwLenMax)'("ILIKE");
      6'd24: kw_text = (8*KwLenMax)'("ORDER");
      6'd25: kw_text = (8*KwLenMax)'("LIMIT");
      6'd26: kw_text = (8*KwLenMax)'("GROUP");
      6'd27: kw_text = (8*KwLenMax)'("FIRST");
      6'd28: kw_text = (8*KwLenMax)'("NULLS");
      6'd29: kw_text = (8*KwLenMax)'("SELECT");
      6'd30: kw_text = (8*KwLenMax)'("OFFSET");
      6'd31: kw_text = (8*KwLenMax)'("HAVING");
      6'd32: kw_text = (8*KwLenMax)'("BETWEEN");
      6'd33: kw_text = (8*KwLenMax)'("EXTRACT");
      6'd34: kw_text = (8*KwLenMax)'("DISTINCT");
      6'd35: kw_text = (8*KwLenMax)'("LOCALTIME");
      6'd36: kw_text = (8*KwLenMax)'("TIMESTAMP");
      6'd37: kw_text = (8*KwLenMax)'({"CURRENT_", "DATE"});
      6'd38: kw_text = (8*KwLenMax)'({"CURRENT_", "TIME"});
      6'd39: kw_text = (8*KwLenMax)'("LOCALTIMESTAMP");
      6'd40: kw_text = (8*KwLenMax)'({"CURRENT_", "TIMESTAMP"});
      default: kw_text = '0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [5:0] k, input logic [4:0] p);
    logic [4:0] n, idx;
    logic [8*KwLenMax-1:0] txt;
    n = kw_len(k);
    txt = kw_text(k);
    idx = n - 5'd1 - p;
    kw_char = (p < n) ? txt[{idx, 3'b000} +: 8] : 8'd0;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sqlx_front.sv
`default_nettype none
module sqlx_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic [7:0]        text_byte,
  input  wire logic              end_of_text,
  output sqlx_pkg::grp_t         grp,
  output logic                   grp_valid
);

  sqlx_pkg::mode_t mode, mode_next;
  logic [15:0] tstart, tstart_next, boff, boff_next, line, line_next;
  logic [15:0] col, col_next, tlen, tlen_next;
  logic [40:0] cand, cand_next;
  sqlx_pkg::grp_t g;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= "0") && (b <= "9");
  endfunction
  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  always_comb begin
    logic [7:0]  b, u;
    logic        taken;
    logic [4:0]  pos;
    logic [15:0] c;
    logic [6:0]  kk;
    b = text_byte;
    u = ((b >= "a") && (b <= "z")) ? b - 8'd32 : b;
    mode_next = mode;
    tstart_next = tstart;
    boff_next = boff;
    line_next = line;
    col_next = col;
    tlen_next = tlen;
    cand_next = cand;
    g = '0;
    taken = 1'b0;
    pos = 5'd0;
    kk = sqlx_pkg::K_IDENT;
    c = 16'd0;

    if (end_of_text) begin
      taken = 1'b0;
    end else begin
      case (mode)
        sqlx_pkg::M_IDENT: begin
          if (is_alpha(b) || is_digit(b) || (b == "_")) begin
            taken = 1'b1;
            pos = (tlen > 16'(sqlx_pkg::KwLenMax)) ? 5'd31 : tlen[4:0];
            for (int k = 0; k < sqlx_pkg::NumKw; k++)
              if (pos >= sqlx_pkg::kw_len(6'(k)) || sqlx_pkg::kw_char(6'(k), pos) != u)
                cand_next[k] = 1'b0;
            boff_next = sqlx_pkg::sat_inc(boff);
            col_next = sqlx_pkg::sat_inc(col);
            tlen_next = sqlx_pkg::sat_inc(tlen);
          end
        end
        sqlx_pkg::M_NUM_INT: begin
          if (is_digit(b)) begin
            taken = 1'b1;
            boff_next = sqlx_pkg::sat_inc(boff);
            col_next = sqlx_pkg::sat_inc(col);
            tlen_next = sqlx_pkg::sat_inc(tlen);
          end else if (b == ".") begin
            taken = 1'b1;
            mode_next = sqlx_pkg::M_NUM_DOT;
          end
        end
        sqlx_pkg::M_NUM_DOT: begin
          if (is_digit(b)) begin
            taken = 1'b1;
            boff_next = sqlx_pkg::sat_inc(sqlx_pkg::sat_inc(boff));
            col_next = sqlx_pkg::sat_inc(sqlx_pkg::sat_inc(col));
            tlen_next = sqlx_pkg::sat_inc(sqlx_pkg::sat_inc(tlen));
            mode_next = sqlx_pkg::M_NUM_FRAC;
          end
        end
        sqlx_pkg::M_NUM_FRAC: begin
          if (is_digit(b)) begin
            taken = 1'b1;
            boff_next = sqlx_pkg::sat_inc(boff);
            col_next = sqlx_pkg::sat_inc(col);
            tlen_next = sqlx_pkg::sat_inc(tlen);
          end
        end
        sqlx_pkg::M_STRING, sqlx_pkg::M_QIDENT: begin
          taken = 1'b1;
          if (mode == sqlx_pkg::M_QIDENT && b == "\"") begin
            boff_next = sqlx_pkg::sat_inc(boff);
            c = sqlx_pkg::sat_inc(col);
            col_next = c;
            g.n = 2'd1;
            g.t0 = '{sqlx_pkg::K_IDENT, tstart, tlen, line,
                     (c >= tlen) ? c - tlen : 16'd0, sqlx_pkg::E_NONE, 1'b0};
            mode_next = sqlx_pkg::M_IDLE;
          end else begin
            c = col;
            if (b == 8'h0A) begin
              line_next = sqlx_pkg::sat_inc(line);
              c = 16'd0;
            end
            boff_next = sqlx_pkg::sat_inc(boff);
            col_next = sqlx_pkg::sat_inc(c);
            tlen_next = sqlx_pkg::sat_inc(tlen);
            if (mode == sqlx_pkg::M_STRING && b == "'") mode_next = sqlx_pkg::M_STRING_QUOTE;
          end
        end
        sqlx_pkg::M_STRING_QUOTE: begin
          if (b == "'") begin
            taken = 1'b1;
            boff_next = sqlx_pkg::sat_inc(boff);
            col_next = sqlx_pkg::sat_inc(col);
            tlen_next = sqlx_pkg::sat_inc(tlen);
            mode_next = sqlx_pkg::M_STRING;
          end
        end
        sqlx_pkg::M_BANG, sqlx_pkg::M_LESS, sqlx_pkg::M_GREATER: begin
          if (b == "=" || (mode == sqlx_pkg::M_LESS && b == ">")) begin
            taken = 1'b1;
            boff_next = sqlx_pkg::sat_inc(boff);
            c = sqlx_pkg::sat_inc(col);
            col_next = c;
            tlen_next = sqlx_pkg::sat_inc(tlen);
            if (mode == sqlx_pkg::M_BANG) kk = sqlx_pkg::K_BANG_EQUAL;
            else if (mode == sqlx_pkg::M_GREATER) kk = sqlx_pkg::K_GREATER_EQUAL;
            else if (b == "=") kk = sqlx_pkg::K_LESS_EQUAL;
            else kk = sqlx_pkg::K_LESS_GREATER;
            g.n = 2'd1;
            g.t0 = '{kk, tstart, tlen_next, line,
                     (c >= tlen_next) ? c - tlen_next : 16'd0, sqlx_pkg::E_NONE, 1'b0};
            mode_next = sqlx_pkg::M_IDLE;
          end
        end
        default: taken = 1'b0;
      endcase
    end

    if (!taken) begin
      // flush the open token
      g.n = 2'd0;
      kk = sqlx_pkg::K_IDENT;
      for (int k = sqlx_pkg::NumKw - 1; k >= 0; k--)
        if (cand[k] && {11'd0, sqlx_pkg::kw_len(6'(k))} == tlen) kk = 7'(k);
      c = (col >= tlen) ? col - tlen : 16'd0;
      case (mode)
        sqlx_pkg::M_IDENT: begin
          g.n = 2'd1;
          g.t0 = '{kk, tstart, tlen, line, c, sqlx_pkg::E_NONE, 1'b0};
        end
        sqlx_pkg::M_NUM_INT, sqlx_pkg::M_NUM_FRAC, sqlx_pkg::M_NUM_DOT: begin
          g.n = 2'd1;
          g.t0 = '{sqlx_pkg::K_NUMBER, tstart, tlen, line, c, sqlx_pkg::E_NONE, 1'b0};
          if (mode == sqlx_pkg::M_NUM_DOT) begin
            g.n = 2'd2;
            g.t1 = '{sqlx_pkg::K_DOT, boff, 16'd1, line,
                     (sqlx_pkg::sat_inc(col) >= 16'd1) ? sqlx_pkg::sat_inc(col) - 16'd1
                                                       : 16'd0,
                     sqlx_pkg::E_NONE, 1'b0};
          end
        end
        sqlx_pkg::M_STRING: begin
          g.n = 2'd1;
          g.t0 = '{sqlx_pkg::K_ERROR, tstart, 16'd0, line, col, sqlx_pkg::E_STRING, 1'b0};
        end
        sqlx_pkg::M_STRING_QUOTE: begin
          g.n = 2'd1;
          g.t0 = '{sqlx_pkg::K_STRING, tstart, tlen, line, c, sqlx_pkg::E_NONE, 1'b0};
        end
        sqlx_pkg::M_QIDENT: begin
          g.n = 2'd1;
          g.t0 = '{sqlx_pkg::K_ERROR, tstart, 16'd0, line, col, sqlx_pkg::E_QIDENT, 1'b0};
        end
        sqlx_pkg::M_BANG: begin
          g.n = 2'd1;
          g.t0 = '{sqlx_pkg::K_ERROR, tstart, 16'd0, line, col, sqlx_pkg::E_CHAR, 1'b0};
        end
        sqlx_pkg::M_LESS: begin
          g.n = 2'd1;
          g.t0 = '{sqlx_pkg::K_LESS, tstart, tlen, line, c, sqlx_pkg::E_NONE, 1'b0};
        end
        sqlx_pkg::M_GREATER: begin
          g.n = 2'd1;
          g.t0 = '{sqlx_pkg::K_GREATER, tstart, tlen, line, c, sqlx_pkg::E_NONE, 1'b0};
        end
        default: g.n = 2'd0;
      endcase
      // state after flush
      begin
        logic [15:0] fb, fc;
        sqlx_pkg::tok_t t;
        logic emit1;
        fb = boff;
        fc = col;
        if (mode == sqlx_pkg::M_NUM_DOT) begin
          fb = sqlx_pkg::sat_inc(boff);
          fc = sqlx_pkg::sat_inc(col);
        end
        mode_next = sqlx_pkg::M_IDLE;
        t = '0;
        emit1 = 1'b0;
        if (end_of_text) begin
          t = '{sqlx_pkg::K_EOF, fb, 16'd0, line, fc, sqlx_pkg::E_NONE, 1'b1};
          emit1 = 1'b1;
          tstart_next = 16'd0;
          boff_next = 16'd0;
          line_next = 16'd1;
          col_next = 16'd0;
          tlen_next = 16'd0;
          cand_next = '1;
        end else if (b == " " || b == 8'h0D || b == 8'h09) begin
          boff_next = sqlx_pkg::sat_inc(fb);
          col_next = sqlx_pkg::sat_inc(fc);
          if (mode == sqlx_pkg::M_NUM_DOT) begin
            tstart_next = boff;
            tlen_next = 16'd1;
          end
        end else if (b == 8'h0A) begin
          boff_next = sqlx_pkg::sat_inc(fb);
          col_next = 16'd1;
          line_next = sqlx_pkg::sat_inc(line);
          if (mode == sqlx_pkg::M_NUM_DOT) begin
            tstart_next = boff;
            tlen_next = 16'd1;
          end
        end else begin
          tstart_next = fb;
          tlen_next = 16'd1;
          cand_next = '1;
          boff_next = sqlx_pkg::sat_inc(fb);
          c = sqlx_pkg::sat_inc(fc);
          col_next = c;
          if (is_alpha(b) || b == "_") begin
            mode_next = sqlx_pkg::M_IDENT;
            for (int k = 0; k < sqlx_pkg::NumKw; k++)
              if (sqlx_pkg::kw_char(6'(k), 5'd0) != u) cand_next[k] = 1'b0;
          end else if (b == "'") begin
            mode_next = sqlx_pkg::M_STRING;
          end else if (b == "\"") begin
            mode_next = sqlx_pkg::M_QIDENT;
            tstart_next = sqlx_pkg::sat_inc(fb);
            tlen_next = 16'd0;
          end else if (is_digit(b)) begin
            mode_next = sqlx_pkg::M_NUM_INT;
          end else if (b == "!") begin
            mode_next = sqlx_pkg::M_BANG;
          end else if (b == "<") begin
            mode_next = sqlx_pkg::M_LESS;
          end else if (b == ">") begin
            mode_next = sqlx_pkg::M_GREATER;
          end else begin
            emit1 = 1'b1;
            kk = sqlx_pkg::K_ERROR;
            case (b)
              "=": kk = sqlx_pkg::K_EQUAL;
              "+": kk = sqlx_pkg::K_SINGLE_BASE;
              "-": kk = sqlx_pkg::K_SINGLE_BASE + 7'd1;
              "*": kk = sqlx_pkg::K_SINGLE_BASE + 7'd2;
              "/": kk = sqlx_pkg::K_SINGLE_BASE + 7'd3;
              "%": kk = sqlx_pkg::K_SINGLE_BASE + 7'd4;
              "&": kk = sqlx_pkg::K_SINGLE_BASE + 7'd5;
              "|": kk = sqlx_pkg::K_SINGLE_BASE + 7'd6;
              "^": kk = sqlx_pkg::K_SINGLE_BASE + 7'd7;
              "(": kk = sqlx_pkg::K_SINGLE_BASE + 7'd8;
              ")": kk = sqlx_pkg::K_SINGLE_BASE + 7'd9;
              ",": kk = sqlx_pkg::K_SINGLE_BASE + 7'd10;
              ".": kk = sqlx_pkg::K_SINGLE_BASE + 7'd11;
              ";": kk = sqlx_pkg::K_SINGLE_BASE + 7'd12;
              default: kk = sqlx_pkg::K_ERROR;
            endcase
            if (kk == sqlx_pkg::K_ERROR)
              t = '{sqlx_pkg::K_ERROR, fb, 16'd0, line, c, sqlx_pkg::E_CHAR, 1'b0};
            else
              t = '{kk, fb, 16'd1, line, (c >= 16'd1) ? c - 16'd1 : 16'd0,
                    sqlx_pkg::E_NONE, 1'b0};
          end
        end
        if (emit1) begin
          case (g.n)
            2'd0: g.t0 = t;
            2'd1: g.t1 = t;
            default: g.t2 = t;
          endcase
          g.n = g.n + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sqlx_pkg::M_IDLE;
      tstart <= 16'd0;
      boff <= 16'd0;
      line <= 16'd1;
      col <= 16'd0;
      tlen <= 16'd0;
      cand <= '1;
    end else if (in_fire) begin
      mode <= mode_next;
      tstart <= tstart_next;
      boff <= boff_next;
      line <= line_next;
      col <= col_next;
      tlen <= tlen_next;
      cand <= cand_next;
    end
  end

  assign grp = g;
  assign grp_valid = in_fire && (g.n != 2'd0);

`ifndef SYNTH
  a_line_pos: assert property (@(posedge clk) disable iff (rst) line != 16'd0)
    else $error("line count zero");
  a_eof_reset: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_text |=> mode == sqlx_pkg::M_IDLE && boff == 16'd0)
    else $error("end did not clear");
  a_grp_max: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> g.n != 2'd3 || end_of_text || mode == sqlx_pkg::M_NUM_DOT)
    else $error("third token without cause");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/sqlx_back.sv
`default_nettype none
module sqlx_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          grp_valid,
  input  sqlx_pkg::grp_t     grp,
  output logic               space_ok,
  output sqlx_pkg::tok_t     tok,
  output logic               tok_valid,
  input  wire logic          tok_ready
);

  // 4-entry group queue; each group emits 1..3 words
  sqlx_pkg::grp_t mem [sqlx_pkg::QueueDepth];
  logic [1:0] wptr, rptr;
  logic [2:0] cnt;
  logic [1:0] sub;
  logic pop, push;
  sqlx_pkg::grp_t head;

  assign head = mem[rptr];
  assign push = grp_valid;
  assign tok_valid = (cnt != 3'd0);
  assign pop = tok_valid && tok_ready && (sub == head.n - 2'd1);
  // registered count only, so input ready never waits on the output side
  assign space_ok = (cnt < 3'(sqlx_pkg::QueueDepth));

  always_comb begin
    case (sub)
      2'd0: tok = head.t0;
      2'd1: tok = head.t1;
      default: tok = head.t2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 2'd0;
      rptr <= 2'd0;
      cnt <= 3'd0;
      sub <= 2'd0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) begin
        rptr <= rptr + 2'd1;
        sub <= 2'd0;
      end else if (tok_valid && tok_ready) begin
        sub <= sub + 2'd1;
      end
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(sqlx_pkg::QueueDepth))
    else $error("queue overflow");
  a_sub_rng: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> sub < head.n)
    else $error("sub index past group");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("word dropped");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/sql_query_lexer.sv
`default_nettype none
// SQL lexer taking one text byte per cycle while in_ready is high. Each byte yields 0..3
// tokens, kept as one group in a four-group queue and sent one token per cycle while
// out_ready is high; a byte's group is queued when the byte is taken, behind any waiting
// groups. Input ready depends only on the queue count: it drops while four groups are
// waiting, so one byte per cycle is sustained whenever the consumer keeps pace. The end
// word flushes the open token, emits EOF with last_of_text set and resets the lexer state.
module sql_query_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       token_kind,
  output logic [15:0]      start_offset,
  output logic [15:0]      token_length,
  output logic [15:0]      line_number,
  output logic [15:0]      column_number,
  output logic [1:0]       error_code,
  output logic             last_of_text
);

  sqlx_pkg::grp_t grp;
  logic grp_valid, space_ok, in_fire;
  sqlx_pkg::tok_t tok;

  assign in_ready = space_ok;
  assign in_fire = in_valid && in_ready;

  sqlx_front u_front (
    .clk, .rst, .in_fire, .text_byte, .end_of_text, .grp, .grp_valid
  );

  sqlx_back u_back (
    .clk, .rst, .grp_valid, .grp, .space_ok, .tok, .tok_valid(out_valid),
    .tok_ready(out_ready)
  );

  assign token_kind = tok.kind;
  assign start_offset = tok.start;
  assign token_length = tok.len;
  assign line_number = tok.line;
  assign column_number = tok.col;
  assign error_code = tok.err;
  assign last_of_text = tok.last;

endmodule
`default_nettype wire

// File: test/sql_query_lexer_checker.sv
`timescale 1ns / 1ps
module sql_query_lexer_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [6:0]  token_kind,
  input  wire logic [15:0] start_offset,
  input  wire logic [15:0] token_length,
  input  wire logic [15:0] line_number,
  input  wire logic [15:0] column_number,
  input  wire logic [1:0]  error_code,
  input  wire logic        last_of_text,
  output int               fails,
  output int               pending
);

  localparam logic [40:0] AllCand = {41{1'b1}};

  string kw_names[41] = '{
    "IN", "IS", "OR", "AS", "BY", "AND", "NOT", "END", "ASC",
    "FROM", "LIKE", "NULL", "TRUE", "CASE", "WHEN", "THEN", "ELSE", "DESC", "LAST", "DATE",
    "TIME", "WHERE", "FALSE", "ILIKE", "ORDER", "LIMIT", "GROUP", "FIRST", "NULLS",
    "SELECT", "OFFSET", "HAVING", "BETWEEN", "EXTRACT", "DISTINCT", "LOCALTIME", "TIMESTAMP",
    string'({"CURRENT_", "DATE"}), string'({"CURRENT_", "TIME"}), "LOCALTIMESTAMP",
    string'({"CURRENT_", "TIMESTAMP"})
  };
  string op_singles = "+-*/%&|^(),.;";

  sqlx_pkg::mode_t mode;
  logic [15:0]     tok_start, byte_pos, line_cnt, col_cnt, tok_len;
  logic [40:0]     cand;
  sqlx_pkg::tok_t  token_q[$];
  int              mism;

  function automatic logic [15:0] incr(input logic [15:0] x);
    return (x == 16'(sqlx_pkg::CountMax)) ? x : x + 16'd1;
  endfunction

  function automatic bit is_dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_let(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  task automatic push_tok(input logic [6:0] k, input logic [15:0] s, input logic [15:0] l,
                          input logic [15:0] c, input logic [1:0] e, input logic last);
    sqlx_pkg::tok_t t;
    t.kind = k; t.start = s; t.len = l; t.line = line_cnt; t.col = c; t.err = e;
    t.last = last;
    token_q.push_back(t);
  endtask

  task automatic close_tok(input logic [6:0] k);
    push_tok(k, tok_start, tok_len, (col_cnt >= tok_len) ? col_cnt - tok_len : 16'd0,
             sqlx_pkg::E_NONE, 1'b0);
    mode = sqlx_pkg::M_IDLE;
  endtask

  task automatic close_err(input logic [1:0] e);
    push_tok(sqlx_pkg::K_ERROR, tok_start, 16'd0, col_cnt, e, 1'b0);
    mode = sqlx_pkg::M_IDLE;
  endtask

  task automatic adv();
    byte_pos = incr(byte_pos);
    col_cnt = incr(col_cnt);
  endtask

  task automatic adv_tok();
    adv();
    tok_len = incr(tok_len);
  endtask

  task automatic newline(input logic [7:0] b);
    if (b == 8'h0A) begin
      line_cnt = incr(line_cnt);
      col_cnt = 16'd0;
    end
  endtask

  task automatic narrow(input logic [7:0] b, input logic [15:0] pos);
    logic [7:0] u;
    u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    for (int k = 0; k < 41; k++) begin
      if (pos >= kw_names[k].len() || kw_names[k][pos] != u) cand[k] = 1'b0;
    end
  endtask

  function automatic logic [6:0] word_kind();
    for (int k = 0; k < 41; k++) begin
      if (cand[k] && kw_names[k].len() == tok_len) return 7'(k);
    end
    return sqlx_pkg::K_IDENT;
  endfunction

  task automatic flush();
    case (mode)
      sqlx_pkg::M_IDENT: close_tok(word_kind());
      sqlx_pkg::M_NUM_INT, sqlx_pkg::M_NUM_FRAC: close_tok(sqlx_pkg::K_NUMBER);
      sqlx_pkg::M_NUM_DOT: begin
        close_tok(sqlx_pkg::K_NUMBER);
        tok_start = byte_pos;
        tok_len = 16'd0;
        adv_tok();
        close_tok(sqlx_pkg::K_DOT);
      end
      sqlx_pkg::M_STRING: close_err(sqlx_pkg::E_STRING);
      sqlx_pkg::M_STRING_QUOTE: close_tok(sqlx_pkg::K_STRING);
      sqlx_pkg::M_QIDENT: close_err(sqlx_pkg::E_QIDENT);
      sqlx_pkg::M_BANG: close_err(sqlx_pkg::E_CHAR);
      sqlx_pkg::M_LESS: close_tok(sqlx_pkg::K_LESS);
      sqlx_pkg::M_GREATER: close_tok(sqlx_pkg::K_GREATER);
      default: ;
    endcase
    mode = sqlx_pkg::M_IDLE;
  endtask

  task automatic begin_tok(input logic [7:0] b);
    if (b == " " || b == 8'h0D || b == 8'h09) begin
      adv();
      return;
    end
    if (b == 8'h0A) begin
      newline(b);
      adv();
      return;
    end
    tok_start = byte_pos;
    tok_len = 16'd0;
    cand = AllCand;
    adv_tok();
    if (is_let(b) || b == "_") begin
      mode = sqlx_pkg::M_IDENT;
      narrow(b, 16'd0);
    end else if (b == "'") begin
      mode = sqlx_pkg::M_STRING;
    end else if (b == "\"") begin
      mode = sqlx_pkg::M_QIDENT;
      tok_start = byte_pos;
      tok_len = 16'd0;
    end else if (is_dig(b)) begin
      mode = sqlx_pkg::M_NUM_INT;
    end else if (b == "!") begin
      mode = sqlx_pkg::M_BANG;
    end else if (b == "<") begin
      mode = sqlx_pkg::M_LESS;
    end else if (b == ">") begin
      mode = sqlx_pkg::M_GREATER;
    end else if (b == "=") begin
      close_tok(sqlx_pkg::K_EQUAL);
    end else begin
      for (int i = 0; i < 13; i++) begin
        if (op_singles[i] == b) begin
          close_tok(sqlx_pkg::K_SINGLE_BASE + 7'(i));
          return;
        end
      end
      close_err(sqlx_pkg::E_CHAR);
    end
  endtask

  function automatic bit takes(input logic [7:0] b);
    case (mode)
      sqlx_pkg::M_IDENT: return is_let(b) || is_dig(b) || b == "_";
      sqlx_pkg::M_NUM_INT: return is_dig(b) || b == ".";
      sqlx_pkg::M_NUM_DOT, sqlx_pkg::M_NUM_FRAC: return is_dig(b);
      sqlx_pkg::M_STRING, sqlx_pkg::M_QIDENT: return 1'b1;
      sqlx_pkg::M_STRING_QUOTE: return b == "'";
      sqlx_pkg::M_BANG, sqlx_pkg::M_GREATER: return b == "=";
      sqlx_pkg::M_LESS: return b == "=" || b == ">";
      default: return 1'b0;
    endcase
  endfunction

  task automatic extend(input logic [7:0] b);
    case (mode)
      sqlx_pkg::M_IDENT: begin
        narrow(b, tok_len);
        adv_tok();
      end
      sqlx_pkg::M_NUM_INT: begin
        if (b == ".") mode = sqlx_pkg::M_NUM_DOT;
        else adv_tok();
      end
      sqlx_pkg::M_NUM_DOT: begin
        adv_tok();
        adv_tok();
        mode = sqlx_pkg::M_NUM_FRAC;
      end
      sqlx_pkg::M_NUM_FRAC: adv_tok();
      sqlx_pkg::M_STRING: begin
        newline(b);
        adv_tok();
        if (b == "'") mode = sqlx_pkg::M_STRING_QUOTE;
      end
      sqlx_pkg::M_STRING_QUOTE: begin
        adv_tok();
        mode = sqlx_pkg::M_STRING;
      end
      sqlx_pkg::M_QIDENT: begin
        if (b == "\"") begin
          adv();
          close_tok(sqlx_pkg::K_IDENT);
        end else begin
          newline(b);
          adv_tok();
        end
      end
      sqlx_pkg::M_BANG: begin
        adv_tok();
        close_tok(sqlx_pkg::K_BANG_EQUAL);
      end
      sqlx_pkg::M_LESS: begin
        adv_tok();
        close_tok(b == "=" ? sqlx_pkg::K_LESS_EQUAL : sqlx_pkg::K_LESS_GREATER);
      end
      sqlx_pkg::M_GREATER: begin
        adv_tok();
        close_tok(sqlx_pkg::K_GREATER_EQUAL);
      end
      default: ;
    endcase
  endtask

  task automatic clear_state();
    mode = sqlx_pkg::M_IDLE;
    tok_start = 16'd0;
    byte_pos = 16'd0;
    line_cnt = 16'd1;
    col_cnt = 16'd0;
    cand = AllCand;
    tok_len = 16'd0;
  endtask

  task automatic lex_word(input logic [7:0] b, input logic eot);
    if (eot) begin
      flush();
      push_tok(sqlx_pkg::K_EOF, byte_pos, 16'd0, col_cnt, sqlx_pkg::E_NONE, 1'b1);
      clear_state();
    end else if (mode != sqlx_pkg::M_IDLE && takes(b)) begin
      extend(b);
    end else begin
      flush();
      begin_tok(b);
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
    mism = 0;
    clear_state();
  end

  always @(posedge clk) begin
    sqlx_pkg::tok_t e;
    if (rst) begin
      clear_state();
      token_q.delete();
    end else begin
      if (in_valid && in_ready) lex_word(text_byte, end_of_text);
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          fails <= fails + 1;
          if (mism < 10) $display("unexpected token kind=%0d", token_kind);
          mism++;
        end else begin
          e = token_q.pop_front();
          if (e.kind != token_kind || e.start != start_offset || e.len != token_length ||
              e.line != line_number || e.col != column_number || e.err != error_code ||
              e.last != last_of_text) begin
            fails <= fails + 1;
            if (mism < 10) begin
              $display("mismatch exp k=%0d s=%0d l=%0d ln=%0d c=%0d e=%0d t=%0d",
                       e.kind, e.start, e.len, e.line, e.col, e.err, e.last);
              $display("         got k=%0d s=%0d l=%0d ln=%0d c=%0d e=%0d t=%0d",
                       token_kind, start_offset, token_length, line_number, column_number,
                       error_code, last_of_text);
            end
            mism++;
          end
        end
      end
    end
    pending <= token_q.size();
  end

endmodule

// File: test/tb_sql_query_lexer.sv
`timescale 1ns / 1ps
module tb_sql_query_lexer;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  token_kind;
  logic [15:0] start_offset, token_length, line_number, column_number;
  logic [1:0]  error_code;
  logic        last_of_text;
  int          fails, pending;
  int          idle_cycles = 0;
  bit          hold_req = 1'b0;
  logic [8:0]  word_q[$];

  sql_query_lexer dut (.*);
  sql_query_lexer_checker chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) word_q.push_back({1'b0, s[i]});
  endtask

  task automatic add_eot();
    word_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic add_random_tok();
    string kws[8] = '{"select", "FROM", "Where", "localtimestamp", "LocalTime", "nulls",
                      "in", "Distinct"};
    string ops[13] = '{"=", "!=", "<", "<=", "<>", ">", ">=", "+", "(", ")", ",", ";", "!"};
    string s;
    logic [7:0] c;
    int n;
    s = "";
    case ($urandom_range(0, 9))
      0, 1: begin
        s = kws[$urandom_range(0, 7)];
        for (int i = 0; i < s.len(); i++) begin
          c = s[i];
          if (is_alpha(c) && $urandom_range(0, 1)) c ^= 8'h20;
          s[i] = c;
        end
      end
      2: begin
        n = $urandom_range(1, 6);
        s = "_";
        for (int i = 0; i < n; i++)
          s = {s, string'(8'($urandom_range(0, 2) == 0 ? "0" + $urandom_range(0, 9)
                                                       : "a" + $urandom_range(0, 25)))};
      end
      3: begin
        s = $sformatf("%0d", $urandom_range(0, 999));
        if ($urandom_range(0, 1)) s = {s, ".", $sformatf("%0d", $urandom_range(0, 99))};
        else if ($urandom_range(0, 2) == 0) s = {s, ".x"};
      end
      4: begin
        s = "'a";
        if ($urandom_range(0, 1)) s = {s, "''"};
        if ($urandom_range(0, 2) == 0) s = {s, "\n"};
        s = {s, "b'"};
      end
      5: s = $urandom_range(0, 1) ? "\"Col\"" : "\"x\ny\"";
      6, 7: s = ops[$urandom_range(0, 12)];
      8: s = string'(8'($urandom_range(0, 255)));
      default: s = $urandom_range(0, 1) ? "\n" : "\t";
    endcase
    add_str(s);
    if ($urandom_range(0, 3) != 0) add_str(" ");
    if ($urandom_range(0, 14) == 0) begin
      if ($urandom_range(0, 3) == 0) add_str($urandom_range(0, 1) ? "'open" : "\"open");
      add_eot();
    end
  endtask

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!rst) break;
    end
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = 150;
      end else begin
        n = draw_gap();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int n;
    logic [8:0] w;
    add_str("Where 3.x!=a<>b");
    add_eot();
    add_str("\"q\n");
    add_eot();
    add_str("'s''\n");
    add_eot();
    word_q.push_back(9'h000);
    word_q.push_back(9'h0FF);
    add_str("!CURRENT_");
    add_str("TIMESTAMP>= Current_");
    add_str("date");
    add_eot();
    while (word_q.size() < 118) add_random_tok();
    add_eot();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < word_q.size(); i++) begin
      w = word_q[i];
      if (i == 70) hold_req = 1'b1;
      if (i == 100) begin
        if (in_valid) in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      n = (i >= 70 && i < 90) ? 0 : draw_gap();
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
      text_byte <= w[7:0];
      end_of_text <= w[8];
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sql_query_lexer.f
hw/rtl/sqlx_pkg.sv
hw/rtl/sqlx_front.sv
hw/rtl/sqlx_back.sv
hw/rtl/sql_query_lexer.sv
test/sql_query_lexer_checker.sv
test/tb_sql_query_lexer.sv
